FILE: design/clt_pkg.sv
// Shared types, constants and keyword tables of the command line tokenizer.
package clt_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int POSITION_BITS_DEF = 16;

    // Characters kept for keyword matching; every keyword fits in it
    localparam int MATCH_CHARS = 8;
    localparam int MATCH_IDX_W = $clog2(MATCH_CHARS);
    localparam int WORD_BITS   = 8 * MATCH_CHARS;

    typedef enum logic [3:0] {
        ST_START,
        ST_ID,
        ST_DISK,
        ST_DOLLAR,
        ST_AT,
        ST_EQ,
        ST_SLASH,
        ST_COMMENT,
        ST_STAR,
        ST_STRING,
        ST_NUM,
        ST_ERRPEND
    } lex_state_t;

    localparam logic [3:0] KIND_COMMAND     = 4'd0;
    localparam logic [3:0] KIND_IDENT       = 4'd1;
    localparam logic [3:0] KIND_DISKFILE    = 4'd2;
    localparam logic [3:0] KIND_DOLLAR_ATTR = 4'd3;
    localparam logic [3:0] KIND_AT_ATTR     = 4'd4;
    localparam logic [3:0] KIND_ARROW       = 4'd5;
    localparam logic [3:0] KIND_STRING      = 4'd6;
    localparam logic [3:0] KIND_NUMBER      = 4'd7;
    localparam logic [3:0] KIND_BAD_ATTR    = 4'd8;
    localparam logic [3:0] KIND_BAD_CHAR    = 4'd9;
    localparam logic [3:0] KIND_OPEN_STRING = 4'd10;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_EQUALS = 8'd61;
    localparam logic [7:0] CH_GT     = 8'd62;
    localparam logic [7:0] CH_AT     = 8'd64;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [7:0] CH_LOW_A  = 8'd97;
    localparam logic [7:0] CH_LOW_D  = 8'd100;
    localparam logic [7:0] CH_LOW_I  = 8'd105;
    localparam logic [7:0] CH_LOW_K  = 8'd107;
    localparam logic [7:0] CH_LOW_S  = 8'd115;
    localparam logic [7:0] CH_LOW_Z  = 8'd122;

    localparam int NUM_CMD    = 15;
    localparam int NUM_DOLLAR = 9;
    localparam int NUM_AT     = 8;

    // Text is right-justified: the first character sits in the highest used byte
    localparam logic [WORD_BITS-1:0] CMD_TEXT [NUM_CMD] = '{
        "mkdisk", "rmdisk", "fdisk", "mount", "unmount", "mkfs", "mkfile", "rm",
        "cp", "mv", "find", "ls", "cat", "loss", "rep"
    };
    localparam logic [3:0] CMD_LEN [NUM_CMD] = '{
        4'd6, 4'd6, 4'd5, 4'd5, 4'd7, 4'd4, 4'd6, 4'd2,
        4'd2, 4'd2, 4'd4, 4'd2, 4'd3, 4'd4, 4'd3
    };

    localparam logic [WORD_BITS-1:0] DOLLAR_TEXT [NUM_DOLLAR] = '{
        "$size", "$path", "$name", "$id", "$fileid", "$dest", "$iddest", "$order",
        "$filen"
    };
    localparam logic [3:0] DOLLAR_LEN [NUM_DOLLAR] = '{
        4'd5, 4'd5, 4'd5, 4'd3, 4'd7, 4'd5, 4'd7, 4'd6, 4'd6
    };

    localparam logic [WORD_BITS-1:0] AT_TEXT [NUM_AT] = '{
        "@unit", "@type", "@fit", "@delete", "@add", "@mov", "@p", "@cont"
    };
    localparam logic [3:0] AT_LEN [NUM_AT] = '{
        4'd5, 4'd5, 4'd4, 4'd7, 4'd4, 4'd4, 4'd2, 4'd5
    };

    // Compare the first len buffered characters against a keyword
    function automatic logic word_hit(input logic [WORD_BITS-1:0] flat,
                                      input logic [WORD_BITS-1:0] txt,
                                      input logic [3:0]           len);
        logic hit;
        int   sh;
        hit = 1'b1;
        for (int i = 0; i < MATCH_CHARS; i++)
        begin
            sh = 8 * (int'(len) - 1 - i);
            if (i < int'(len))
            begin
                if (flat[8*i +: 8] != txt[sh +: 8])
                begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

FILE: design/clt_stream_if.sv
// Valid/ready stream interfaces for the character input and the token output.
interface clt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface clt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [3:0]  keyword_index;
    logic [7:0]  token_length;
    logic [15:0] start_position;
    logic        truncated;
    logic        last_of_run;

    modport source (output valid, output token_kind, output keyword_index,
                    output token_length, output start_position, output truncated,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input keyword_index,
                    input token_length, input start_position, input truncated,
                    input last_of_run, output ready);
endinterface

FILE: design/command_line_tokenizer_unit.sv
// Command line tokenizer: one character per cycle in, at most one token out.
// A token is in the output register in the cycle after the character that ends it is taken.
// Throughput: one character per cycle while the output register is free or being taken.
// A full output register that is not taken stalls the input.
// Reset clears the lexer state, counters, position and halt flag at once; no clearing pass.
module command_line_tokenizer_unit #(
    parameter int MAX_TOKEN_LEN = clt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = clt_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    clt_char_if.sink    char_stream,
    clt_token_if.source token_stream
);
    import clt_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

    lex_state_t               st_reg, st_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     halt_reg, halt_next;
    logic                     trunc_reg, trunc_next;
    logic [7:0]               match_buf_reg [MATCH_CHARS];
    logic [WORD_BITS-1:0]     match_flat;

    logic                     out_valid_reg;
    logic [3:0]               kind_reg, idx_reg;
    logic [7:0]               len_reg;
    logic [15:0]              start_pos_reg;
    logic                     trunc_out_reg;

    logic       in_fire;
    logic [7:0] c;
    logic       eoi;

    // character classes
    logic is_lower, is_digit, is_word, is_disk, is_blank;

    // restart decode: c taken as the first character of something new
    lex_state_t rs_state;
    logic       rs_begin, rs_add, rs_bad;

    // keyword matches
    logic       cmd_hit, dol_hit, at_hit;
    logic [3:0] cmd_idx, dol_idx, at_idx;
    logic [3:0] fin_kind, fin_idx;

    // actions of the current transaction
    logic a_begin, a_add, a_fin, a_bad, a_pend, a_arrow, a_str, a_clear, a_adv, a_mark;

    logic             res_emit;
    logic [3:0]       res_kind, res_idx;
    logic [CNT_W-1:0] res_cnt;
    logic [POSITION_BITS-1:0] res_start;
    logic             res_trunc;

    logic [CNT_W-1:0] base_cnt;
    logic             base_trunc;
    logic             wr_en;

    assign c       = char_stream.char_code;
    assign eoi     = char_stream.end_of_input;
    assign char_stream.ready = !out_valid_reg || token_stream.ready;
    assign in_fire = char_stream.valid && char_stream.ready;

    assign is_lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_word  = is_lower || is_digit || (c == CH_UNDER);
    assign is_disk  = (c == CH_DOT) || (c == CH_LOW_D) || (c == CH_LOW_I) ||
                      (c == CH_LOW_K) || (c == CH_LOW_S);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);

    always_comb
    begin
        rs_state = ST_START;
        rs_begin = 1'b0;
        rs_add   = 1'b0;
        rs_bad   = 1'b0;
        if (is_lower)
        begin
            rs_begin = 1'b1;
            rs_add   = 1'b1;
            rs_state = ST_ID;
        end
        else if (c == CH_DOLLAR)
        begin
            rs_begin = 1'b1;
            rs_add   = 1'b1;
            rs_state = ST_DOLLAR;
        end
        else if (c == CH_AT)
        begin
            rs_begin = 1'b1;
            rs_add   = 1'b1;
            rs_state = ST_AT;
        end
        else if (c == CH_EQUALS)
        begin
            rs_begin = 1'b1;
            rs_add   = 1'b1;
            rs_state = ST_EQ;
        end
        else if (c == CH_SLASH)
        begin
            rs_state = ST_SLASH;
        end
        else if (c == CH_QUOTE)
        begin
            rs_begin = 1'b1;
            rs_state = ST_STRING;
        end
        else if (is_digit)
        begin
            rs_begin = 1'b1;
            rs_add   = 1'b1;
            rs_state = ST_NUM;
        end
        else if (!is_blank)
        begin
            rs_bad = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MATCH_CHARS; i++)
        begin
            match_flat[8*i +: 8] = match_buf_reg[i];
        end
    end

    // parallel constant matches against the three keyword lists
    always_comb
    begin
        cmd_hit = 1'b0;
        cmd_idx = '0;
        for (int i = 0; i < NUM_CMD; i++)
        begin
            if (!cmd_hit && cnt_reg == CNT_W'(CMD_LEN[i]) &&
                word_hit(match_flat, CMD_TEXT[i], CMD_LEN[i]))
            begin
                cmd_hit = 1'b1;
                cmd_idx = 4'(i);
            end
        end
        dol_hit = 1'b0;
        dol_idx = '0;
        for (int i = 0; i < NUM_DOLLAR; i++)
        begin
            if (!dol_hit && cnt_reg == CNT_W'(DOLLAR_LEN[i]) &&
                word_hit(match_flat, DOLLAR_TEXT[i], DOLLAR_LEN[i]))
            begin
                dol_hit = 1'b1;
                dol_idx = 4'(i);
            end
        end
        at_hit = 1'b0;
        at_idx = '0;
        for (int i = 0; i < NUM_AT; i++)
        begin
            if (!at_hit && cnt_reg == CNT_W'(AT_LEN[i]) &&
                word_hit(match_flat, AT_TEXT[i], AT_LEN[i]))
            begin
                at_hit = 1'b1;
                at_idx = 4'(i);
            end
        end
    end

    // kind of the pending token if it ends now
    always_comb
    begin
        fin_idx = '0;
        case (st_reg)
            ST_ID:
            begin
                fin_kind = cmd_hit ? KIND_COMMAND : KIND_IDENT;
                fin_idx  = cmd_idx;
            end
            ST_DISK:   fin_kind = KIND_DISKFILE;
            ST_NUM:    fin_kind = KIND_NUMBER;
            ST_DOLLAR:
            begin
                fin_kind = dol_hit ? KIND_DOLLAR_ATTR : KIND_BAD_ATTR;
                fin_idx  = dol_idx;
            end
            ST_AT:
            begin
                fin_kind = at_hit ? KIND_AT_ATTR : KIND_BAD_ATTR;
                fin_idx  = at_idx;
            end
            default:   fin_kind = KIND_OPEN_STRING;
        endcase
    end

    // next state and actions
    always_comb
    begin
        st_next = st_reg;
        a_begin = 1'b0;
        a_add   = 1'b0;
        a_fin   = 1'b0;
        a_bad   = 1'b0;
        a_pend  = 1'b0;
        a_arrow = 1'b0;
        a_str   = 1'b0;
        a_clear = 1'b0;
        a_adv   = 1'b0;
        a_mark  = 1'b0;
        if (in_fire && eoi)
        begin
            a_clear = 1'b1;
            st_next = ST_START;
            if (!halt_reg)
            begin
                if (st_reg == ST_ID || st_reg == ST_DISK || st_reg == ST_NUM ||
                    st_reg == ST_DOLLAR || st_reg == ST_AT || st_reg == ST_STRING)
                begin
                    a_fin = 1'b1;
                end
                else if (st_reg == ST_ERRPEND)
                begin
                    a_pend = 1'b1;
                end
            end
        end
        else if (in_fire && !halt_reg)
        begin
            a_adv = 1'b1;
            case (st_reg)
                ST_ERRPEND:
                begin
                    a_pend  = 1'b1;
                    st_next = ST_START;
                end
                ST_ID, ST_DISK, ST_NUM, ST_DOLLAR, ST_AT:
                begin
                    if ((st_reg == ST_ID || st_reg == ST_DOLLAR || st_reg == ST_AT) && is_word)
                    begin
                        a_add = 1'b1;
                    end
                    else if (st_reg == ST_ID && c == CH_DOT)
                    begin
                        a_add   = 1'b1;
                        st_next = ST_DISK;
                    end
                    else if ((st_reg == ST_DISK && is_disk) || (st_reg == ST_NUM && is_digit))
                    begin
                        a_add = 1'b1;
                    end
                    else
                    begin
                        a_fin = 1'b1;
                        if (fin_kind == KIND_BAD_ATTR)
                        begin
                            // the character after an unknown attribute is consumed
                            st_next = ST_START;
                        end
                        else
                        begin
                            a_begin = rs_begin;
                            a_add   = rs_add;
                            a_mark  = rs_bad;
                            st_next = rs_bad ? ST_ERRPEND : rs_state;
                        end
                    end
                end
                ST_EQ, ST_SLASH, ST_STAR, ST_START:
                begin
                    if (st_reg == ST_EQ && c == CH_GT)
                    begin
                        a_add   = 1'b1;
                        a_arrow = 1'b1;
                        st_next = ST_START;
                    end
                    else if (st_reg == ST_SLASH && c == CH_STAR)
                    begin
                        st_next = ST_COMMENT;
                    end
                    else if (st_reg == ST_STAR && c == CH_SLASH)
                    begin
                        st_next = ST_START;
                    end
                    else
                    begin
                        a_begin = rs_begin;
                        a_add   = rs_add;
                        a_mark  = rs_bad;
                        a_bad   = rs_bad;
                        st_next = rs_state;
                    end
                end
                ST_COMMENT:
                begin
                    if (c == CH_STAR)
                    begin
                        st_next = ST_STAR;
                    end
                end
                ST_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        a_str   = 1'b1;
                        st_next = ST_START;
                    end
                    else
                    begin
                        a_add = 1'b1;
                    end
                end
                default: st_next = ST_START;
            endcase
        end
    end

    // token counters, position and match buffer write
    always_comb
    begin
        cnt_next   = cnt_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        halt_next  = halt_reg;
        trunc_next = trunc_reg;
        base_cnt   = a_begin ? '0 : cnt_reg;
        base_trunc = a_begin ? 1'b0 : trunc_reg;
        wr_en      = 1'b0;
        if (a_clear)
        begin
            cnt_next   = '0;
            start_next = '0;
            pos_next   = '0;
            halt_next  = 1'b0;
            trunc_next = 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (a_begin || a_mark)
            begin
                start_next = pos_reg;
            end
            cnt_next   = base_cnt;
            trunc_next = base_trunc;
            if (a_add)
            begin
                wr_en = base_cnt < CNT_W'(MATCH_CHARS);
                if (base_cnt < CNT_W'(MAX_TOKEN_LEN))
                begin
                    cnt_next = base_cnt + 1'b1;
                end
                else
                begin
                    trunc_next = 1'b1;
                end
            end
            if (a_bad || a_pend)
            begin
                halt_next = 1'b1;
            end
        end
    end

    // result of the current transaction
    always_comb
    begin
        res_emit  = 1'b1;
        res_kind  = fin_kind;
        res_idx   = fin_idx;
        res_cnt   = cnt_reg;
        res_start = start_reg;
        res_trunc = trunc_reg;
        if (a_fin)
        begin
            res_kind = fin_kind;
        end
        else if (a_pend || a_bad)
        begin
            res_kind  = KIND_BAD_CHAR;
            res_idx   = '0;
            res_cnt   = CNT_W'(1);
            res_start = a_bad ? pos_reg : start_reg;
            res_trunc = 1'b0;
        end
        else if (a_arrow)
        begin
            res_kind  = KIND_ARROW;
            res_idx   = '0;
            res_cnt   = cnt_next;
            res_trunc = trunc_next;
        end
        else if (a_str)
        begin
            res_kind = KIND_STRING;
            res_idx  = '0;
        end
        else
        begin
            res_emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_START;
            cnt_reg       <= '0;
            start_reg     <= '0;
            pos_reg       <= '0;
            halt_reg      <= 1'b0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            halt_reg  <= halt_next;
            trunc_reg <= trunc_next;
            if (in_fire)
            begin
                out_valid_reg <= res_emit;
            end
            else if (token_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            match_buf_reg[base_cnt[MATCH_IDX_W-1:0]] <= c;
        end
        if (in_fire && res_emit)
        begin
            kind_reg      <= res_kind;
            idx_reg       <= res_idx;
            len_reg       <= 8'(res_cnt);
            start_pos_reg <= 16'(res_start);
            trunc_out_reg <= res_trunc;
        end
    end

    assign token_stream.valid          = out_valid_reg;
    assign token_stream.token_kind     = kind_reg;
    assign token_stream.keyword_index  = idx_reg;
    assign token_stream.token_length   = len_reg;
    assign token_stream.start_position = start_pos_reg;
    assign token_stream.truncated      = trunc_out_reg;
    assign token_stream.last_of_run    = 1'b1;

    // a halted line yields nothing until end of input
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && halt_reg && !eoi |=> !out_valid_reg)
        else $error("result produced while halted");

    // a bad character inside the line halts the lexer
    a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !eoi && res_emit && res_kind == KIND_BAD_CHAR |=> halt_reg)
        else $error("bad character did not halt");

    // the deferred bad character state is entered only behind a token result
    a_pend_behind_token: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_ERRPEND && st_next == ST_ERRPEND |-> res_emit && a_fin)
        else $error("deferred bad character without a token");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TOKEN_LEN))
        else $error("token count beyond maximum");

endmodule
